[src/gnp_pkg.sv]
// package with constants, codes and types of the grid nearest point depth buffer
`timescale 1ns / 1ps
package gnp_pkg;

  // grid and index space
  localparam int GRID_COLS  = 512;
  localparam int GRID_ROWS  = 256;
  localparam int MAX_POINTS = 65536;
  localparam int NCELLS     = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W     = (NCELLS > 1) ? $clog2(NCELLS) : 1;

  // opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BLOCK_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_BLOCK_HEIGHT = 2'd3;

  // confidence arithmetic
  localparam logic [25:0] CONF_NUM   = 26'd65536000;
  localparam logic [18:0] DEPTH_BIAS = 19'd1000;
  localparam int          CONF_STEPS = 26;
  localparam int          COORD_STEPS = 12;

  typedef struct packed {
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [6:0]  block_width;
    logic [6:0]  block_height;
  } gnp_cfg_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [1:0]        op;
    logic              in_grid;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       point;
    logic [17:0]       depth;
  } gnp_item_t;

  // one stored cell
  typedef struct packed {
    logic        valid;
    logic [17:0] depth;
    logic [15:0] point;
    logic [15:0] conf;
  } gnp_entry_t;

  localparam int ENTRY_W = $bits(gnp_entry_t);

endpackage

[src/gnp_in_if.sv]
// input channel interface of the depth buffer
`timescale 1ns / 1ps
interface gnp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] point_index;
  logic signed [15:0] pixel_u;
  logic signed [15:0] pixel_v;
  logic [17:0] depth_mm;

  modport source (output valid, opcode, point_index, pixel_u, pixel_v, depth_mm,
                  input ready);
  modport sink (input valid, opcode, point_index, pixel_u, pixel_v, depth_mm,
                output ready);
endinterface

[src/gnp_out_if.sv]
// result channel interface of the depth buffer
`timescale 1ns / 1ps
interface gnp_out_if;
  logic        valid;
  logic        ready;
  logic        in_grid;
  logic        hit;
  logic [15:0] confidence;
  logic        cell_occupied;
  logic [17:0] cell_depth;
  logic [15:0] cell_point;

  modport source (output valid, in_grid, hit, confidence, cell_occupied, cell_depth,
                  cell_point, input ready);
  modport sink (input valid, in_grid, hit, confidence, cell_occupied, cell_depth,
                cell_point, output ready);
endinterface

[src/grid_nearest_point_depth_buffer.sv]
// top level of the grid nearest point depth buffer
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid / ready      opcode, point_index, pixel_u, pixel_v, depth_mm
//   out_ch    source     valid / ready      in_grid, hit, confidence, cell_occupied,
//                                           cell_depth, cell_point
//   cfg_*     sink       cfg_we             cfg_index, cfg_data
//
// front runs the 12 step coordinate divider for in-image inserts and queries only
// and passes the rest straight on
// back runs the 26 step confidence divider for in-grid inserts and queries only
// and not for dropped transactions; a two entry queue decouples the two
// a clear sweeps the cell memory, one cell a cycle, and gives its result at the end
// after reset the same sweep runs and in_ch.ready stays low until it ends
// out_ch holds its result in a register; its stalls fill the queue and then block in_ch
`timescale 1ns / 1ps
module grid_nearest_point_depth_buffer import gnp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gnp_in_if.sink      in_ch,
  gnp_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  gnp_cfg_t  cfg_r;
  logic      fq_valid, fq_ready;
  gnp_item_t fq_item;
  logic      bq_valid, bq_ready;
  gnp_item_t bq_item;
  logic      init_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= 12'd1920;
      cfg_r.image_height <= 12'd1080;
      cfg_r.block_width  <= 7'd6;
      cfg_r.block_height <= 7'd6;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data;
        CFG_BLOCK_WIDTH:  cfg_r.block_width  <= cfg_data[6:0];
        CFG_BLOCK_HEIGHT: cfg_r.block_height <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  gnp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .hold    (init_busy),
    .in_ch   (in_ch),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_item  (fq_item)
  );

  gnp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_item   (bq_item)
  );

  gnp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .q_item    (bq_item),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

endmodule

[src/gnp_ram.sv]
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module gnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/gnp_front.sv]
// front end: accepts transactions, range checks and divides pixel to cell
`timescale 1ns / 1ps
module gnp_front import gnp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  gnp_cfg_t  cfg,
  input  logic      hold,
  gnp_in_if.sink    in_ch,
  output logic      q_valid,
  input  logic      q_ready,
  output gnp_item_t q_item
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]  state_r;
  logic [3:0]  step_r;
  logic [1:0]  op_r;
  logic        need_div_r;
  logic [15:0] point_r;
  logic [17:0] depth_r;
  logic [6:0]  bw_r, bh_r;
  logic [11:0] qu_r, qv_r;
  logic [6:0]  remu_r, remv_r;

  logic        coord_ok;
  logic        idx_ok;
  logic [7:0]  tu, tv;
  logic [24:0] lin;
  logic        cell_ok;

  // early classification of the incoming transaction
  assign idx_ok = {5'd0, in_ch.point_index} < 21'(MAX_POINTS);
  assign coord_ok = !in_ch.pixel_u[15] && !in_ch.pixel_v[15] &&
                    (in_ch.pixel_u < $signed({4'd0, cfg.image_width})) &&
                    (in_ch.pixel_v < $signed({4'd0, cfg.image_height}));

  assign in_ch.ready = (state_r == F_IDLE) && !hold;

  // restoring divider trial values
  assign tu = {remu_r, qu_r[11]};
  assign tv = {remv_r, qv_r[11]};

  // cell address and grid bound
  assign cell_ok = (13'(qu_r) < 13'(GRID_COLS)) && (13'(qv_r) < 13'(GRID_ROWS));
  assign lin     = 25'(qv_r) * 25'(GRID_COLS) + 25'(qu_r);

  assign q_valid        = (state_r == F_PUSH);
  assign q_item.op      = op_r;
  assign q_item.in_grid = need_div_r && cell_ok;
  assign q_item.addr    = ADDR_W'(lin);
  assign q_item.point   = point_r;
  assign q_item.depth   = depth_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            step_r  <= '0;
            state_r <= ((in_ch.opcode == OP_INSERT || in_ch.opcode == OP_QUERY) &&
                        idx_ok && coord_ok) ? F_DIV : F_PUSH;
          end
        end
        F_DIV: begin
          step_r <= step_r + 4'd1;
          if (step_r == 4'(COORD_STEPS - 1)) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (q_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // payload and dividers
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_ch.valid && in_ch.ready) begin
      op_r       <= in_ch.opcode;
      point_r    <= in_ch.point_index;
      depth_r    <= in_ch.depth_mm;
      need_div_r <= (in_ch.opcode == OP_INSERT || in_ch.opcode == OP_QUERY) &&
                    idx_ok && coord_ok;
      bw_r       <= (cfg.block_width == '0) ? 7'd1 : cfg.block_width;
      bh_r       <= (cfg.block_height == '0) ? 7'd1 : cfg.block_height;
      qu_r       <= in_ch.pixel_u[11:0];
      qv_r       <= in_ch.pixel_v[11:0];
      remu_r     <= '0;
      remv_r     <= '0;
    end else if (state_r == F_DIV) begin
      if (tu >= {1'b0, bw_r}) begin
        remu_r <= 7'(tu - {1'b0, bw_r});
        qu_r   <= {qu_r[10:0], 1'b1};
      end else begin
        remu_r <= tu[6:0];
        qu_r   <= {qu_r[10:0], 1'b0};
      end
      if (tv >= {1'b0, bh_r}) begin
        remv_r <= 7'(tv - {1'b0, bh_r});
        qv_r   <= {qv_r[10:0], 1'b1};
      end else begin
        remv_r <= tv[6:0];
        qv_r   <= {qv_r[10:0], 1'b0};
      end
    end
  end

endmodule

[src/gnp_queue.sv]
// two entry queue between front and back
`timescale 1ns / 1ps
module gnp_queue import gnp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  gnp_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output gnp_item_t pop_item
);

  gnp_item_t slot_r [2];
  logic      rd_r, wr_r;
  logic [1:0] cnt_r;
  logic      do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = slot_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= !wr_r;
      if (do_pop)  rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_item;
    end
  end

endmodule

[src/gnp_back.sv]
// back end: cell read-modify-write, confidence divider, clear sweep, result register
`timescale 1ns / 1ps
module gnp_back import gnp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  gnp_item_t q_item,
  output logic      init_busy,
  gnp_out_if.source out_ch
);

  localparam logic [2:0] B_INIT = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_RD   = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_FIN  = 3'd4;
  localparam logic [2:0] B_CLR  = 3'd5;

  logic [2:0]        state_r;
  logic [ADDR_W-1:0] sweep_r;
  logic [4:0]        step_r;
  gnp_item_t         item_r;
  gnp_entry_t        ent_r;
  logic [18:0]       den_r;
  logic [25:0]       num_r;
  logic [19:0]       rem_r;
  logic [16:0]       quo_r;

  logic              out_valid_r;
  logic              out_in_grid_r, out_hit_r, out_occ_r;
  logic [15:0]       out_conf_r, out_point_r;
  logic [17:0]       out_depth_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  gnp_entry_t        ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  gnp_entry_t        rd_ent;
  logic [20:0]       trial;
  logic [15:0]       conf_sat;
  logic              replace;
  logic              sweeping;
  logic              sweep_last;
  logic              out_set;

  assign rd_ent     = gnp_entry_t'(ram_rdata);
  assign sweeping   = (state_r == B_INIT) || (state_r == B_CLR);
  assign sweep_last = (sweep_r == ADDR_W'(NCELLS - 1));
  assign init_busy  = (state_r == B_INIT);
  assign q_ready    = (state_r == B_IDLE) && !out_valid_r;
  assign trial      = {rem_r, num_r[25]};
  assign conf_sat   = quo_r[16] ? 16'hFFFF : quo_r[15:0];
  assign replace    = (item_r.op == OP_INSERT) &&
                      (!ent_r.valid || item_r.depth < ent_r.depth);

  // result becomes valid: end of clear, end of cell update, or dropped transaction
  assign out_set = ((state_r == B_CLR) && sweep_last) || (state_r == B_FIN) ||
                   ((state_r == B_IDLE) && q_valid && q_ready &&
                    (q_item.op != OP_CLEAR) && !q_item.in_grid);

  // ram write mux: sweep or cell update
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = item_r.addr;
    ram_wdata = '{valid: 1'b1, depth: item_r.depth, point: item_r.point, conf: conf_sat};
    if (sweeping) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_r;
      ram_wdata = '0;
    end else if (state_r == B_FIN && item_r.in_grid && replace) begin
      ram_we = 1'b1;
    end
  end

  gnp_ram #(.WIDTH(ENTRY_W), .DEPTH(NCELLS)) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (q_item.addr),
    .rdata (ram_rdata)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      sweep_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_INIT, B_CLR: begin
          if (sweep_last) begin
            sweep_r <= '0;
            state_r <= B_IDLE;
          end else begin
            sweep_r <= sweep_r + ADDR_W'(1);
          end
        end
        B_IDLE: begin
          if (q_valid && q_ready) begin
            if (q_item.op == OP_CLEAR) begin
              state_r <= B_CLR;
            end else if (q_item.in_grid) begin
              state_r <= B_RD;
            end
          end
        end
        B_RD: begin
          step_r  <= '0;
          state_r <= B_DIV;
        end
        B_DIV: begin
          step_r <= step_r + 5'd1;
          if (step_r == 5'(CONF_STEPS - 1)) begin
            state_r <= B_FIN;
          end
        end
        B_FIN: begin
          state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (q_valid && q_ready) begin
          item_r        <= q_item;
          out_in_grid_r <= 1'b0;
          out_hit_r     <= 1'b0;
          out_conf_r    <= '0;
          out_occ_r     <= 1'b0;
          out_depth_r   <= '0;
          out_point_r   <= '0;
        end
      end
      B_RD: begin
        ent_r <= rd_ent;
        den_r <= DEPTH_BIAS + 19'(item_r.depth);
        num_r <= CONF_NUM + 26'((DEPTH_BIAS + 19'(item_r.depth)) >> 1);
        rem_r <= '0;
        quo_r <= '0;
      end
      B_DIV: begin
        num_r <= {num_r[24:0], 1'b0};
        if (trial >= {2'd0, den_r}) begin
          rem_r <= 20'(trial - {2'd0, den_r});
          quo_r <= {quo_r[15:0], 1'b1};
        end else begin
          rem_r <= trial[19:0];
          quo_r <= {quo_r[15:0], 1'b0};
        end
      end
      B_FIN: begin
        out_in_grid_r <= 1'b1;
        if (replace) begin
          out_hit_r   <= 1'b1;
          out_conf_r  <= conf_sat;
          out_occ_r   <= 1'b1;
          out_depth_r <= item_r.depth;
          out_point_r <= item_r.point;
        end else begin
          out_hit_r   <= (item_r.op == OP_QUERY) && ent_r.valid &&
                         (ent_r.point == item_r.point);
          out_conf_r  <= ((item_r.op == OP_QUERY) && ent_r.valid &&
                          (ent_r.point == item_r.point)) ? ent_r.conf : 16'd0;
          out_occ_r   <= ent_r.valid;
          out_depth_r <= ent_r.valid ? ent_r.depth : 18'd0;
          out_point_r <= ent_r.valid ? ent_r.point : 16'd0;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.in_grid       = out_in_grid_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.confidence    = out_conf_r;
  assign out_ch.cell_occupied = out_occ_r;
  assign out_ch.cell_depth    = out_depth_r;
  assign out_ch.cell_point    = out_point_r;

endmodule

[sim/grid_nearest_point_depth_buffer_tb.sv]
// testbench of the grid nearest point depth buffer: directed and random inserts, queries, clears
`timescale 1ns / 1ps
module grid_nearest_point_depth_buffer_tb;
  import gnp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic [15:0]        idx;
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic [17:0]        mm;
  } point_req_t;

  typedef struct {
    logic        in_grid;
    logic        hit;
    logic [15:0] conf;
    logic        occ;
    logic [17:0] depth;
    logic [15:0] point;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_IMAGE_WIDTH;
  logic [11:0] cfg_data = '0;

  gnp_in_if  in_ch ();
  gnp_out_if out_ch ();

  grid_nearest_point_depth_buffer DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the configuration and the cell store
  logic [11:0] img_w = 12'd1920, img_h = 12'd1080;
  logic [6:0]  blk_w = 7'd6, blk_h = 7'd6;
  logic [17:0] shadow_depth [int];
  logic [15:0] shadow_point [int];
  logic [15:0] shadow_conf [int];

  point_req_t   pending_points [$];
  point_req_t   inserted_log [$];
  cell_result_t expected_results [$];
  point_req_t   cur_req;

  int n_errors = 0, n_sent = 0, n_checked = 0, n_added = 0;
  int n_hits = 0, n_dropped = 0, n_clears = 0;
  int in_gap = 0, out_gap = 0, hold_cnt = 0;
  bit hold_done = 0, in_idle = 0, out_idle = 0;
  logic nxt_valid;

  function automatic logic [15:0] depth_confidence(logic [17:0] mm);
    int unsigned den, q;
    den = 1000 + mm;
    q = (65536000 + den / 2) / den;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  // cell address or -1 when the point falls outside image or grid
  function automatic int cell_address(point_req_t r);
    int unsigned uu, vv, bw, bh, gu, gv;
    uu = r.u[15:0];
    vv = r.v[15:0];
    bw = (blk_w == 0) ? 1 : blk_w;
    bh = (blk_h == 0) ? 1 : blk_h;
    if (r.u < 0 || r.v < 0) return -1;
    if (uu >= img_w || vv >= img_h) return -1;
    gu = uu / bw;
    gv = vv / bh;
    if (gu >= GRID_COLS || gv >= GRID_ROWS) return -1;
    return gv * GRID_COLS + gu;
  endfunction

  // apply one accepted transaction to the shadow store and queue its result
  function automatic void predict_cell_update(point_req_t r);
    cell_result_t res;
    int a;
    res = '{default: '0};
    if (r.op == OP_CLEAR) begin
      shadow_depth.delete();
      shadow_point.delete();
      shadow_conf.delete();
      n_clears++;
    end else if (r.op != OP_UNUSED) begin
      a = cell_address(r);
      if (a < 0) n_dropped++;
      else begin
        res.in_grid = 1'b1;
        if (r.op == OP_INSERT) begin
          if (!shadow_depth.exists(a) || r.mm < shadow_depth[a]) begin
            shadow_depth[a] = r.mm;
            shadow_point[a] = r.idx;
            shadow_conf[a]  = depth_confidence(r.mm);
            res.hit  = 1'b1;
            res.conf = shadow_conf[a];
          end
        end else if (shadow_depth.exists(a) && shadow_point[a] == r.idx) begin
          res.hit  = 1'b1;
          res.conf = shadow_conf[a];
        end
        if (shadow_depth.exists(a)) begin
          res.occ   = 1'b1;
          res.depth = shadow_depth[a];
          res.point = shadow_point[a];
        end
        if (res.hit) n_hits++;
      end
    end
    expected_results.insert(expected_results.size(), res);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", n_checked, what, got, want);
    n_errors++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      nxt_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        predict_cell_update(cur_req);
        n_sent++;
        nxt_valid = 1'b0;
        in_gap = in_idle ? $urandom_range(0, 11) : 0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) in_gap--;
        else if (pending_points.size() > 0) begin
          cur_req = pending_points.pop_front();
          in_ch.opcode      <= cur_req.op;
          in_ch.point_index <= cur_req.idx;
          in_ch.pixel_u     <= cur_req.u;
          in_ch.pixel_v     <= cur_req.v;
          in_ch.depth_mm    <= cur_req.mm;
          nxt_valid = 1'b1;
        end
      end
      in_ch.valid <= nxt_valid;
    end
  end

  // one long receiver hold-off so the block fills up and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (!hold_done && n_sent >= 330) begin
      hold_cnt  <= 3000;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result transaction", 1, 0);
        end else begin
          cell_result_t e;
          e = expected_results.pop_front();
          if (out_ch.in_grid !== e.in_grid) report_mismatch("in_grid", out_ch.in_grid, e.in_grid);
          if (out_ch.hit !== e.hit) report_mismatch("hit", out_ch.hit, e.hit);
          if (out_ch.confidence !== e.conf)
            report_mismatch("confidence", out_ch.confidence, e.conf);
          if (out_ch.cell_occupied !== e.occ)
            report_mismatch("cell_occupied", out_ch.cell_occupied, e.occ);
          if (out_ch.cell_depth !== e.depth)
            report_mismatch("cell_depth", out_ch.cell_depth, e.depth);
          if (out_ch.cell_point !== e.point)
            report_mismatch("cell_point", out_ch.cell_point, e.point);
        end
        n_checked++;
        out_gap = out_idle ? $urandom_range(0, 11) : 0;
      end else if (out_gap > 0) begin
        out_gap--;
      end
      out_ch.ready <= (hold_cnt == 0 && out_gap == 0);
    end
  end

  // one random transaction shaped around the current configuration
  function automatic point_req_t random_point();
    point_req_t r;
    int unsigned pick, win_u, win_v;
    pick = $urandom_range(0, 99);
    r.op = (pick < 55) ? OP_INSERT : (pick < 97) ? OP_QUERY : OP_UNUSED;
    r.idx = $urandom;
    r.mm = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
    win_u = ((blk_w == 0) ? 1 : blk_w) * 3;
    win_v = ((blk_h == 0) ? 1 : blk_h) * 3;
    pick = $urandom_range(0, 99);
    if (r.op == OP_QUERY && inserted_log.size() > 0 && $urandom_range(0, 9) < 6) begin
      point_req_t p;
      p = inserted_log[$urandom_range(0, inserted_log.size() - 1)];
      r.idx = p.idx;
      r.u = p.u;
      r.v = p.v;
    end else if (pick < 50) begin
      r.u = $urandom_range(0, (win_u < img_w) ? win_u : img_w - 1);
      r.v = $urandom_range(0, (win_v < img_h) ? win_v : img_h - 1);
      if (r.op == OP_INSERT) r.idx = $urandom_range(0, 40);
    end else if (pick < 85) begin
      r.u = $urandom_range(0, img_w - 1);
      r.v = $urandom_range(0, img_h - 1);
    end else begin
      r.u = $urandom;
      r.v = $urandom;
    end
    if (r.op == OP_INSERT) begin
      inserted_log.insert(inserted_log.size(), r);
      if (inserted_log.size() > 64) void'(inserted_log.pop_front());
    end
    return r;
  endfunction

  // append one transaction to the pending list and count it
  function automatic void enqueue_point(point_req_t r);
    pending_points.insert(pending_points.size(), r);
    n_added++;
  endfunction

  function automatic void add_point(logic [1:0] op, logic [15:0] idx, int u, int v,
                                    logic [17:0] mm);
    point_req_t r;
    r.op = op; r.idx = idx; r.u = u; r.v = v; r.mm = mm;
    enqueue_point(r);
  endfunction

  task automatic add_random(int n);
    repeat (n) enqueue_point(random_point());
  endtask

  // wait until every queued transaction has produced its checked result
  task automatic wait_idle();
    while (n_checked < n_added)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_config(logic [11:0] w, logic [11:0] h, logic [6:0] bw, logic [6:0] bh);
    @(posedge clk); cfg_we <= 1'b1; cfg_index <= CFG_IMAGE_WIDTH;  cfg_data <= w;
    @(posedge clk); cfg_index <= CFG_IMAGE_HEIGHT; cfg_data <= h;
    @(posedge clk); cfg_index <= CFG_BLOCK_WIDTH;  cfg_data <= {5'd0, bw};
    @(posedge clk); cfg_index <= CFG_BLOCK_HEIGHT; cfg_data <= {5'd0, bh};
    @(posedge clk); cfg_we <= 1'b0;
    img_w = w; img_h = h; blk_w = bw; blk_h = bh;
  endtask

  // stimulus sequence
  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_INSERT;
    in_ch.point_index = '0;
    in_ch.pixel_u = '0;
    in_ch.pixel_v = '0;
    in_ch.depth_mm = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed cases on the reset configuration
    add_point(OP_QUERY,  16'd5,     0,      0,      18'd0);
    add_point(OP_INSERT, 16'd0,     0,      0,      18'd500);
    add_point(OP_INSERT, 16'd1,     5,      5,      18'd800);
    add_point(OP_INSERT, 16'd2,     3,      1,      18'd500);
    add_point(OP_INSERT, 16'd3,     1,      2,      18'd200);
    add_point(OP_QUERY,  16'd3,     4,      4,      18'd0);
    add_point(OP_QUERY,  16'd0,     0,      0,      18'd0);
    add_point(OP_INSERT, 16'hFFFF,  1919,   1079,   18'h3FFFF);
    add_point(OP_INSERT, 16'd7,     1914,   1074,   18'd0);
    add_point(OP_QUERY,  16'd7,     1919,   1079,   18'd0);
    add_point(OP_INSERT, 16'd8,     -1,     10,     18'd10);
    add_point(OP_INSERT, 16'd8,     10,     -1,     18'd10);
    add_point(OP_INSERT, 16'd8,     1920,   10,     18'd10);
    add_point(OP_INSERT, 16'd8,     10,     1080,   18'd10);
    add_point(OP_INSERT, 16'd9,     -32768, 32767,  18'd10);
    add_point(OP_QUERY,  16'd9,     32767,  -32768, 18'd10);
    add_point(OP_UNUSED, 16'hFFFF,  1,      1,      18'h3FFFF);
    add_point(OP_INSERT, 16'd10,    600,    600,    18'd1000);
    add_point(OP_CLEAR,  16'd0,     0,      0,      18'd0);
    add_point(OP_QUERY,  16'd3,     1,      2,      18'd0);
    add_point(OP_INSERT, 16'd11,    1,      2,      18'd300);
    wait_idle();
    in_idle = 1; out_idle = 1;
    add_random(100);
    wait_idle();

    // widest image, single pixel cells: grid edge bounds the columns and rows
    write_config(12'd4095, 12'd4095, 7'd1, 7'd1);
    inserted_log.delete();
    add_point(OP_INSERT, 16'd20, 511, 255, 18'd40);
    add_point(OP_INSERT, 16'd21, 512, 0,   18'd40);
    add_point(OP_INSERT, 16'd22, 0,   256, 18'd40);
    add_random(60);
    add_point(OP_CLEAR, 16'd0, 0, 0, 18'd0);
    add_random(40);
    wait_idle();

    // one pixel image, 64 by 64 pixel cells
    write_config(12'd1, 12'd1, 7'd64, 7'd64);
    in_idle = 0; out_idle = 1;
    inserted_log.delete();
    add_point(OP_INSERT, 16'd30, 1, 0, 18'd40);
    add_random(60);
    wait_idle();

    // zero block size acts as one; long receiver hold-off falls here
    write_config(12'd700, 12'd300, 7'd0, 7'd0);
    in_idle = 0; out_idle = 0;
    add_point(OP_CLEAR, 16'd0, 0, 0, 18'd0);
    inserted_log.delete();
    add_random(80);
    wait_idle();

    // largest image with 64 by 64 pixel cells
    write_config(12'd4095, 12'd4095, 7'd64, 7'd64);
    in_idle = 1; out_idle = 1;
    inserted_log.delete();
    add_random(100);
    wait_idle();
    repeat (200) @(posedge clk);

    $display("covered %0d transactions, %0d results, %0d hits, %0d dropped, %0d clears",
             n_sent, n_checked, n_hits, n_dropped, n_clears);
    $display("five configurations including zero block size and one pixel image");
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
src/gnp_pkg.sv
src/gnp_in_if.sv
src/gnp_out_if.sv
src/gnp_ram.sv
src/gnp_front.sv
src/gnp_queue.sv
src/gnp_back.sv
src/grid_nearest_point_depth_buffer.sv
sim/grid_nearest_point_depth_buffer_tb.sv
